### sv/knxgv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// knxgv_pkg
// Shared types and codes for the group value decoder: telegram word, result
// word, status and value kind codes, datapoint main types.
// ----------------------------------------------------------------------------
package knxgv_pkg;

    // telegram word
    typedef struct packed {
        logic [7:0] frame_byte0;
        logic [7:0] frame_byte1;
        logic [7:0] frame_byte2;
        logic [7:0] frame_byte3;
        logic [7:0] frame_byte4;
        logic [7:0] frame_byte5;
        logic [7:0] frame_length;
    } t_frame;

    // result word
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  value_kind;
        logic [31:0] value_bits;
    } t_result;

    // configuration registers
    typedef struct packed {
        logic [7:0] dpt_main;
        logic [7:0] dpt_sub;
    } t_dpt_cfg;

    // configuration register indexes
    localparam logic [7:0] CFG_DPT_MAIN = 8'd0;
    localparam logic [7:0] CFG_DPT_SUB  = 8'd1;

    // application layer service codes
    localparam logic [3:0] APCI_RESPONSE = 4'd1;
    localparam logic [3:0] APCI_WRITE    = 4'd2;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_WRITE   = 2'd1;
    localparam logic [1:0] ST_SHORT       = 2'd2;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

    // value kinds
    localparam logic [2:0] KIND_BOOL       = 3'd0;
    localparam logic [2:0] KIND_UNSIGNED   = 3'd1;
    localparam logic [2:0] KIND_SIGNED32   = 3'd2;
    localparam logic [2:0] KIND_HUNDREDTHS = 3'd3;
    localparam logic [2:0] KIND_FLOAT32    = 3'd4;

    // datapoint main types
    localparam logic [7:0] DPT_BOOL    = 8'd1;
    localparam logic [7:0] DPT_U8      = 8'd5;
    localparam logic [7:0] DPT_U16     = 8'd7;
    localparam logic [7:0] DPT_F16     = 8'd9;
    localparam logic [7:0] DPT_S32     = 8'd13;
    localparam logic [7:0] DPT_F32     = 8'd14;
    localparam logic [7:0] DPT_ENUM8   = 8'd20;

    // one-byte subtypes with scaling
    localparam logic [7:0] SUB_PERCENT = 8'd1;
    localparam logic [7:0] SUB_ANGLE   = 8'd3;

    // scale factors
    localparam logic [8:0] SCALE_PERCENT = 9'd100;
    localparam logic [8:0] SCALE_ANGLE   = 9'd360;

endpackage
`default_nettype wire

### sv/knxgv_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// knxgv_decode
// Combinational decode of one telegram by the configured datapoint type:
// service check, length check, value extraction and scaling.
// ----------------------------------------------------------------------------
module knxgv_decode (
    input  wire knxgv_pkg::t_frame    i_frame,
    input  wire knxgv_pkg::t_dpt_cfg  i_cfg,
    output knxgv_pkg::t_result        o_result
);
    import knxgv_pkg::*;

    logic [3:0]  apci;
    logic [8:0]  scale;
    logic [16:0] scaled;
    logic [24:0] scaled_x257;
    logic [8:0]  quot_est;
    logic [16:0] rem_est;
    logic [8:0]  quot;
    logic [11:0] mant;
    logic [3:0]  expo;
    logic [31:0] f16_bits;
    logic [31:0] word32;

    // service code from bytes 0 and 1
    assign apci = {i_frame.frame_byte0[1:0], i_frame.frame_byte1[7:6]};

    // one-byte scaling: x / 255 via x * 257 / 65536 and one correction step
    always_comb begin
        scale = (i_cfg.dpt_sub == SUB_ANGLE) ? SCALE_ANGLE : SCALE_PERCENT;
        scaled = 17'({9'd0, i_frame.frame_byte2} * {8'd0, scale});
        scaled_x257 = {scaled, 8'd0} + {8'd0, scaled};
        quot_est = scaled_x257[24:16];
        rem_est = scaled - (17'({quot_est, 8'd0}) - 17'(quot_est));
        quot = (rem_est >= 17'd255) ? quot_est + 9'd1 : quot_est;
    end

    // two-byte float: 12-bit two's complement mantissa shifted by exponent
    always_comb begin
        mant = {i_frame.frame_byte2[7], i_frame.frame_byte2[2:0], i_frame.frame_byte3};
        expo = i_frame.frame_byte2[6:3];
        f16_bits = 32'($signed({{20{mant[11]}}, mant}) <<< expo);
    end

    assign word32 = {i_frame.frame_byte2, i_frame.frame_byte3,
                     i_frame.frame_byte4, i_frame.frame_byte5};

    // status and value selection
    always_comb begin
        o_result = '0;
        if (apci != APCI_WRITE && apci != APCI_RESPONSE) begin
            o_result.status = ST_NOT_WRITE;
        end else if (i_frame.frame_length < 8'd2) begin
            o_result.status = ST_SHORT;
        end else begin
            unique case (i_cfg.dpt_main)
                DPT_BOOL: begin
                    o_result.value_kind = KIND_BOOL;
                    o_result.value_bits = {31'd0, i_frame.frame_byte1[0]};
                end
                DPT_U8: begin
                    o_result.value_kind = KIND_UNSIGNED;
                    if (i_cfg.dpt_sub == SUB_PERCENT || i_cfg.dpt_sub == SUB_ANGLE) begin
                        o_result.value_bits = {23'd0, quot};
                    end else begin
                        o_result.value_bits = {24'd0, i_frame.frame_byte2};
                    end
                end
                DPT_ENUM8: begin
                    o_result.value_kind = KIND_UNSIGNED;
                    o_result.value_bits = {24'd0, i_frame.frame_byte2};
                end
                DPT_U16: begin
                    o_result.value_kind = KIND_UNSIGNED;
                    o_result.value_bits = {16'd0, i_frame.frame_byte2, i_frame.frame_byte3};
                end
                DPT_F16: begin
                    o_result.value_kind = KIND_HUNDREDTHS;
                    o_result.value_bits = f16_bits;
                end
                DPT_S32: begin
                    o_result.value_kind = KIND_SIGNED32;
                    o_result.value_bits = word32;
                end
                DPT_F32: begin
                    o_result.value_kind = KIND_FLOAT32;
                    o_result.value_bits = word32;
                end
                default: begin
                    o_result.status = ST_UNSUPPORTED;
                end
            endcase

            // per-type minimum length
            case (i_cfg.dpt_main) inside
                DPT_U8, DPT_ENUM8: begin
                    if (i_frame.frame_length < 8'd3) begin
                        o_result = '0;
                        o_result.status = ST_SHORT;
                    end
                end
                DPT_U16, DPT_F16: begin
                    if (i_frame.frame_length < 8'd4) begin
                        o_result = '0;
                        o_result.status = ST_SHORT;
                    end
                end
                DPT_S32, DPT_F32: begin
                    if (i_frame.frame_length < 8'd6) begin
                        o_result = '0;
                        o_result.status = ST_SHORT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### sv/knx_group_value_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// knx_group_value_decoder
// Decodes one group telegram payload by the configured datapoint main and
// sub type into a status, a value kind and a 32-bit value.
// ----------------------------------------------------------------------------
// o_done follows start through the input register and the result register
// throughput: one word per cycle; busy stays low, the decode is one pass of
//   logic between the two registers
// reset: synchronous, active low; clears the valid flags and dpt_main/dpt_sub
// results are shown for one cycle under o_done; the receiver cannot stall
// ----------------------------------------------------------------------------
module knx_group_value_decoder (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // command side
    input  wire                  start,
    output logic                 busy,
    input  wire knxgv_pkg::t_frame i_frame,
    // result side
    output logic                 o_done,
    output knxgv_pkg::t_result   o_result,
    // configuration write channel
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [7:0]           i_cfg_index,
    input  wire  [7:0]           i_cfg_data
);
    import knxgv_pkg::*;

    logic     r_in_valid;
    t_frame   r_in;
    logic     r_out_valid;
    t_result  r_out;
    t_dpt_cfg r_cfg;
    t_result  n_out;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_DPT_MAIN) begin
                r_cfg.dpt_main <= i_cfg_data;
            end else if (i_cfg_index == CFG_DPT_SUB) begin
                r_cfg.dpt_sub <= i_cfg_data;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_frame;
        end
    end

    // decode
    knxgv_decode u_decode (
        .i_frame  (r_in),
        .i_cfg    (r_cfg),
        .o_result (n_out)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_done   = r_out_valid;
    assign o_result = r_out;

endmodule
`default_nettype wire
